/* hw/rtl/vss_pkg.sv */
// Shared types, register indexes and reset constants for the speech segmenter.
package vss_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned PROB_WIDTH_DEF  = 16;
  localparam int unsigned WIN_WIDTH       = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 3;

  // Register reset values; probability values are Q0.16 (0.5 and 0.15).
  localparam logic [31:0] THRESH_RESET      = 32'd32768;
  localparam logic [31:0] GAP_RESET         = 32'd9830;
  localparam logic [WIN_WIDTH-1:0] WIN_RESET = 16'd1024;
  localparam logic [31:0] MIN_SIL_RESET     = 32'd0;
  localparam logic [31:0] SPLIT_PAUSE_RESET = 32'd1568;
  localparam logic [31:0] MIN_SPEECH_RESET  = 32'd1024;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_GAP         = 3'd1,
    CFG_WINDOW      = 3'd2,
    CFG_MIN_SILENCE = 3'd3,
    CFG_SPLIT_PAUSE = 3'd4,
    CFG_MIN_SPEECH  = 3'd5,
    CFG_MAX_SPEECH  = 3'd6
  } vss_cfg_idx_e;

  typedef enum logic [1:0] {
    REASON_SILENCE = 2'd0,
    REASON_SPLIT   = 2'd1,
    REASON_EOS     = 2'd2
  } vss_reason_e;

  typedef enum logic {
    KIND_PROB = 1'b0,
    KIND_EOS  = 1'b1
  } vss_kind_e;

endpackage

/* hw/rtl/vss_core.sv */
// Segment state registers and the per-item decision logic.
module vss_core import vss_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned PROB_WIDTH  = PROB_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   kind_i,
  input  logic [PROB_WIDTH-1:0]  prob_i,
  input  logic [COUNT_WIDTH-1:0] stream_len_i,
  input  logic [PROB_WIDTH-1:0]  thresh_i,
  input  logic [PROB_WIDTH-1:0]  gap_i,
  input  logic [WIN_WIDTH-1:0]   window_i,
  input  logic [COUNT_WIDTH-1:0] min_sil_i,
  input  logic [COUNT_WIDTH-1:0] split_pause_i,
  input  logic [COUNT_WIDTH-1:0] min_speech_i,
  input  logic [COUNT_WIDTH-1:0] max_speech_i,
  output logic                   res_valid_o,
  output logic [COUNT_WIDTH-1:0] res_start_o,
  output logic [COUNT_WIDTH-1:0] res_end_o,
  output vss_reason_e            res_reason_o
);

  logic                   in_speech_q, in_speech_d;
  logic                   sil_valid_q, sil_valid_d;
  logic                   pause_valid_q, pause_valid_d;
  logic                   resumed_q, resumed_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] sil_start_q, sil_start_d;
  logic [COUNT_WIDTH-1:0] pause_end_q, pause_end_d;
  logic [COUNT_WIDTH-1:0] resume_q, resume_d;
  logic [COUNT_WIDTH-1:0] open_q, open_d;

  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] sil_s;
  logic [COUNT_WIDTH-1:0] sil_len;
  logic [COUNT_WIDTH-1:0] open_len;
  logic [COUNT_WIDTH-1:0] speech_len;
  logic [PROB_WIDTH-1:0]  low;
  logic                   is_speech;
  logic                   is_silence;
  logic                   split_hit;

  assign count_next = count_q + COUNT_WIDTH'(window_i);
  assign low        = (thresh_i > gap_i) ? thresh_i - gap_i : '0;
  assign is_speech  = prob_i >= thresh_i;
  assign is_silence = prob_i < low;
  assign open_len   = count_next - open_q;
  assign split_hit  = in_speech_q && (max_speech_i != '1) && (open_len > max_speech_i);
  // A silence run starts at the end of its first silent window.
  assign sil_s      = sil_valid_q ? sil_start_q : count_next;
  assign sil_len    = count_next - sil_s;
  assign speech_len = sil_s - open_q;

  always_comb begin
    in_speech_d   = in_speech_q;
    sil_valid_d   = sil_valid_q;
    pause_valid_d = pause_valid_q;
    resumed_d     = resumed_q;
    count_d       = count_q;
    sil_start_d   = sil_start_q;
    pause_end_d   = pause_end_q;
    resume_d      = resume_q;
    open_d        = open_q;
    res_valid_o   = 1'b0;
    res_start_o   = open_q;
    res_end_o     = count_next;
    res_reason_o  = REASON_SILENCE;

    if (kind_i == KIND_EOS) begin
      res_valid_o   = in_speech_q;
      res_end_o     = stream_len_i;
      res_reason_o  = REASON_EOS;
      in_speech_d   = 1'b0;
      sil_valid_d   = 1'b0;
      pause_valid_d = 1'b0;
      resumed_d     = 1'b0;
      count_d       = '0;
      sil_start_d   = '0;
      pause_end_d   = '0;
      resume_d      = '0;
      open_d        = '0;
    end else begin
      count_d = count_next;
      if (is_speech) begin
        if (sil_valid_q) begin
          sil_valid_d = 1'b0;
          sil_start_d = '0;
          if (pause_valid_q && !resumed_q) begin
            resume_d  = count_q;
            resumed_d = 1'b1;
          end
        end
        if (!in_speech_q) begin
          in_speech_d = 1'b1;
          open_d      = count_q;
        end
      end else if (split_hit) begin
        res_valid_o   = 1'b1;
        res_reason_o  = REASON_SPLIT;
        res_end_o     = pause_valid_q ? pause_end_q : count_next;
        in_speech_d   = pause_valid_q && resumed_q;
        open_d        = (pause_valid_q && resumed_q) ? resume_q : '0;
        sil_valid_d   = 1'b0;
        pause_valid_d = 1'b0;
        resumed_d     = 1'b0;
        sil_start_d   = '0;
        pause_end_d   = '0;
        resume_d      = '0;
      end else if (is_silence && in_speech_q) begin
        sil_valid_d = 1'b1;
        sil_start_d = sil_s;
        if (sil_len > split_pause_i) begin
          pause_end_d   = sil_s;
          pause_valid_d = 1'b1;
          resumed_d     = 1'b0;
        end
        if (sil_len >= min_sil_i && speech_len > min_speech_i) begin
          res_valid_o   = 1'b1;
          res_end_o     = sil_s;
          res_reason_o  = REASON_SILENCE;
          in_speech_d   = 1'b0;
          open_d        = '0;
          sil_valid_d   = 1'b0;
          pause_valid_d = 1'b0;
          resumed_d     = 1'b0;
          sil_start_d   = '0;
          pause_end_d   = '0;
          resume_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_speech_q   <= 1'b0;
      sil_valid_q   <= 1'b0;
      pause_valid_q <= 1'b0;
      resumed_q     <= 1'b0;
      count_q       <= '0;
      sil_start_q   <= '0;
      pause_end_q   <= '0;
      resume_q      <= '0;
      open_q        <= '0;
    end else if (step_i) begin
      in_speech_q   <= in_speech_d;
      sil_valid_q   <= sil_valid_d;
      pause_valid_q <= pause_valid_d;
      resumed_q     <= resumed_d;
      count_q       <= count_d;
      sil_start_q   <= sil_start_d;
      pause_end_q   <= pause_end_d;
      resume_q      <= resume_d;
      open_q        <= open_d;
    end
  end

endmodule

/* hw/rtl/vad_speech_segmenter.sv */
// Flow: an accepted item is held in the input register, and its result, if any,
// is registered in the output register when the item leaves the input register.
// Throughput: one item per cycle; the input register empties whenever the
// output register is empty or being taken, so stall only follows out_stall_i.
// Reset: asynchronous, active low; clears the segment state and pipeline valids
// and loads the configuration registers with their reset values.
module vad_speech_segmenter import vss_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned PROB_WIDTH  = PROB_WIDTH_DEF,
  localparam int unsigned CfgWidth   = (COUNT_WIDTH > PROB_WIDTH) ? COUNT_WIDTH : PROB_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [PROB_WIDTH-1:0]    speech_prob_i,
  input  logic [COUNT_WIDTH-1:0]   stream_length_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [COUNT_WIDTH-1:0]   seg_start_o,
  output logic [COUNT_WIDTH-1:0]   seg_end_o,
  output logic [1:0]               end_reason_o
);

  logic [PROB_WIDTH-1:0]  thresh_q, gap_q;
  logic [WIN_WIDTH-1:0]   window_q;
  logic [COUNT_WIDTH-1:0] min_sil_q, split_pause_q, min_speech_q, max_speech_q;

  logic                   in_valid_q;
  logic                   kind_q;
  logic [PROB_WIDTH-1:0]  prob_q;
  logic [COUNT_WIDTH-1:0] stream_len_q;

  logic                   out_valid_q;
  logic [COUNT_WIDTH-1:0] start_q, end_q;
  vss_reason_e            reason_q;

  logic                   advance;
  logic                   accept;
  logic                   res_valid;
  logic [COUNT_WIDTH-1:0] res_start, res_end;
  vss_reason_e            res_reason;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= PROB_WIDTH'(THRESH_RESET);
      gap_q         <= PROB_WIDTH'(GAP_RESET);
      window_q      <= WIN_RESET;
      min_sil_q     <= COUNT_WIDTH'(MIN_SIL_RESET);
      split_pause_q <= COUNT_WIDTH'(SPLIT_PAUSE_RESET);
      min_speech_q  <= COUNT_WIDTH'(MIN_SPEECH_RESET);
      max_speech_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:   thresh_q      <= cfg_data_i[PROB_WIDTH-1:0];
        CFG_GAP:         gap_q         <= cfg_data_i[PROB_WIDTH-1:0];
        CFG_WINDOW:      window_q      <= cfg_data_i[WIN_WIDTH-1:0];
        CFG_MIN_SILENCE: min_sil_q     <= cfg_data_i[COUNT_WIDTH-1:0];
        CFG_SPLIT_PAUSE: split_pause_q <= cfg_data_i[COUNT_WIDTH-1:0];
        CFG_MIN_SPEECH:  min_speech_q  <= cfg_data_i[COUNT_WIDTH-1:0];
        CFG_MAX_SPEECH:  max_speech_q  <= cfg_data_i[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q       <= kind_i;
      prob_q       <= speech_prob_i;
      stream_len_q <= stream_length_i;
    end
  end

  vss_core #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .PROB_WIDTH (PROB_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .kind_i       (kind_q),
    .prob_i       (prob_q),
    .stream_len_i (stream_len_q),
    .thresh_i     (thresh_q),
    .gap_i        (gap_q),
    .window_i     (window_q),
    .min_sil_i    (min_sil_q),
    .split_pause_i(split_pause_q),
    .min_speech_i (min_speech_q),
    .max_speech_i (max_speech_q),
    .res_valid_o  (res_valid),
    .res_start_o  (res_start),
    .res_end_o    (res_end),
    .res_reason_o (res_reason)
  );

  // Output register; an item with no result just leaves it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      start_q  <= res_start;
      end_q    <= res_end;
      reason_q <= res_reason;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seg_start_o  = start_q;
  assign seg_end_o    = end_q;
  assign end_reason_o = reason_q;

endmodule

/* dv/tb_vad_speech_segmenter.sv */
// Self-checking testbench for vad_speech_segmenter: random traffic, in-bench segment predictor.
module tb_vad_speech_segmenter;
  import vss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COUNT_WIDTH_DEF-1:0] count_t;
  typedef logic [PROB_WIDTH_DEF-1:0]  prob_t;
  typedef logic [WIN_WIDTH-1:0]       win_t;
  typedef logic [CFG_IDX_WIDTH-1:0]   idx_t;

  typedef enum {ACT_WINDOW, ACT_REG, ACT_DRAIN, ACT_HOLD} act_e;
  typedef enum {RUN_SPEECH, RUN_BAND, RUN_SILENCE, RUN_NOISE} run_e;

  typedef struct {
    act_e      act;
    vss_kind_e kind;
    prob_t     prob;
    count_t    len;
    idx_t      idx;
    count_t    data;
  } stim_t;

  typedef struct {
    count_t      start;
    count_t      stop;
    vss_reason_e reason;
  } segment_t;

  localparam idx_t        CFG_UNUSED    = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RUN_LIMIT     = 1000000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 240;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_we_i = 1'b0;
  idx_t   cfg_idx_i = '0;
  count_t cfg_data_i = '0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  logic   kind_i = 1'b0;
  prob_t  speech_prob_i = '0;
  count_t stream_length_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  count_t seg_start_o;
  count_t seg_end_o;
  logic [1:0] end_reason_o;

  vad_speech_segmenter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .speech_prob_i   (speech_prob_i),
    .stream_length_i (stream_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .seg_start_o     (seg_start_o),
    .seg_end_o       (seg_end_o),
    .end_reason_o    (end_reason_o)
  );

  stim_t    windows_to_send[$];
  segment_t segments_due[$];

  int unsigned cycle_cnt = 0;
  int unsigned bad_segments = 0;
  int unsigned settle = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  bit          item_taken = 1'b0;

  // Register copies
  prob_t  thr_r        = THRESH_RESET[PROB_WIDTH_DEF-1:0];
  prob_t  gap_r        = GAP_RESET[PROB_WIDTH_DEF-1:0];
  win_t   win_r        = WIN_RESET;
  count_t min_sil_r    = MIN_SIL_RESET;
  count_t pause_len_r  = SPLIT_PAUSE_RESET;
  count_t min_speech_r = MIN_SPEECH_RESET;
  count_t max_len_r    = '1;

  // Segment tracking state
  bit     in_seg = 1'b0;
  count_t sample_cnt = '0;
  count_t sil_start = '0;
  count_t pause_end = '0;
  count_t resume_at = '0;
  count_t open_at = '0;
  bit     sil_ok = 1'b0;
  bit     pause_ok = 1'b0;
  bit     resumed = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------- predictor ----------------

  function automatic void post_segment(count_t s, count_t e, vss_reason_e r);
    segment_t seg;
    seg.start  = s;
    seg.stop   = e;
    seg.reason = r;
    segments_due = {segments_due, seg};
  endfunction

  function automatic void close_open();
    in_seg    = 1'b0;
    open_at   = '0;
    sil_start = '0;
    pause_end = '0;
    resume_at = '0;
    sil_ok    = 1'b0;
    pause_ok  = 1'b0;
    resumed   = 1'b0;
  endfunction

  function automatic void load_register(idx_t idx, count_t d);
    case (idx)
      CFG_THRESHOLD:   thr_r        = d[PROB_WIDTH_DEF-1:0];
      CFG_GAP:         gap_r        = d[PROB_WIDTH_DEF-1:0];
      CFG_WINDOW:      win_r        = d[WIN_WIDTH-1:0];
      CFG_MIN_SILENCE: min_sil_r    = d;
      CFG_SPLIT_PAUSE: pause_len_r  = d;
      CFG_MIN_SPEECH:  min_speech_r = d;
      CFG_MAX_SPEECH:  max_len_r    = d;
      default: ;
    endcase
  endfunction

  function automatic void track_window(logic kind, prob_t prob, count_t len);
    count_t win_start;
    count_t low;
    count_t quiet;
    count_t nxt;
    bit     reopen;
    if (kind == KIND_EOS) begin
      if (in_seg) post_segment(open_at, len, REASON_EOS);
      close_open();
      sample_cnt = '0;
    end else begin
      win_start  = sample_cnt;
      sample_cnt = sample_cnt + count_t'(win_r);
      if (prob >= thr_r) begin
        if (sil_ok) begin
          sil_ok    = 1'b0;
          sil_start = '0;
          if (pause_ok && !resumed) begin
            resume_at = win_start;
            resumed   = 1'b1;
          end
        end
        if (!in_seg) begin
          in_seg  = 1'b1;
          open_at = win_start;
        end
      end else if (in_seg && max_len_r != '1 && count_t'(sample_cnt - open_at) > max_len_r)
      begin
        if (pause_ok) begin
          reopen = resumed;
          nxt    = resume_at;
          post_segment(open_at, pause_end, REASON_SPLIT);
          close_open();
          if (reopen) begin
            in_seg  = 1'b1;
            open_at = nxt;
          end
        end else begin
          post_segment(open_at, sample_cnt, REASON_SPLIT);
          close_open();
        end
      end else begin
        // lower edge of the hysteresis band saturates at zero
        low = (thr_r > gap_r) ? count_t'(thr_r - gap_r) : '0;
        if (count_t'(prob) < low && in_seg) begin
          if (!sil_ok) begin
            sil_start = sample_cnt;
            sil_ok    = 1'b1;
          end
          quiet = sample_cnt - sil_start;
          if (quiet > pause_len_r) begin
            pause_end = sil_start;
            pause_ok  = 1'b1;
            resumed   = 1'b0;
          end
          if (quiet >= min_sil_r && count_t'(sil_start - open_at) > min_speech_r) begin
            post_segment(open_at, sil_start, REASON_SILENCE);
            close_open();
          end
        end
      end
    end
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (((cycle_cnt / 3000) % 5) == 2) return 0;   // stretch with no idling
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_window(prob_t p);
    stim_t s;
    s.act  = ACT_WINDOW;
    s.kind = KIND_PROB;
    s.prob = p;
    s.len  = $urandom();
    s.idx  = '0;
    s.data = '0;
    windows_to_send = {windows_to_send, s};
  endfunction

  function automatic void add_eos(count_t len);
    stim_t s;
    s.act  = ACT_WINDOW;
    s.kind = KIND_EOS;
    s.prob = prob_t'($urandom());
    s.len  = len;
    s.idx  = '0;
    s.data = '0;
    windows_to_send = {windows_to_send, s};
  endfunction

  function automatic void add_reg(idx_t idx, count_t d);
    stim_t s;
    s.act  = ACT_REG;
    s.kind = KIND_PROB;
    s.prob = '0;
    s.len  = '0;
    s.idx  = idx;
    s.data = d;
    windows_to_send = {windows_to_send, s};
  endfunction

  function automatic void add_marker(act_e a);
    stim_t s;
    s.act  = a;
    s.kind = KIND_PROB;
    s.prob = '0;
    s.len  = '0;
    s.idx  = '0;
    s.data = '0;
    windows_to_send = {windows_to_send, s};
  endfunction

  // 16-bit registers get junk in the upper half of the write data
  function automatic count_t pad16(logic [15:0] v);
    count_t junk;
    junk = $urandom();
    return {junk[31:16], v};
  endfunction

  function automatic count_t pick_len(win_t w, int unsigned m);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return count_t'(w) * $urandom_range(0, m) + $urandom_range(0, w);
  endfunction

  function automatic prob_t pick_prob(run_e t, prob_t thr_v, prob_t low_v);
    case (t)
      RUN_SPEECH:  return prob_t'($urandom_range(thr_v, 65535));
      RUN_BAND:    if (thr_v > low_v) return prob_t'($urandom_range(low_v, thr_v - 1));
      RUN_SILENCE: if (low_v > 0) return prob_t'($urandom_range(0, low_v - 1));
      default: ;
    endcase
    return prob_t'($urandom());
  endfunction

  function automatic count_t pick_stream_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // ---------------- stimulus and end of run ----------------

  initial begin
    prob_t       thr_p, gap_p, low_p;
    win_t        win_p;
    count_t      min_sil_p, pause_p, speech_p, max_p;
    run_e        t;
    int unsigned n, run_len;

    // reset configuration: threshold 32768, band down to 22938, window 1024
    add_window(16'd0);
    add_window(16'd65535);
    add_window(16'd32768);
    add_window(16'd32767);
    add_window(16'd22938);
    add_window(16'd22937);     // closes on silence
    add_eos('1);               // nothing open
    add_window(16'd65535);
    add_eos('1);
    add_window(16'd65535);
    add_eos('0);

    // split with no pause recorded
    add_reg(CFG_WINDOW, pad16(16'd500));
    add_reg(CFG_SPLIT_PAUSE, '1);
    add_reg(CFG_MIN_SILENCE, '1);
    add_reg(CFG_MAX_SPEECH, 32'd2000);
    add_window(16'd65535);
    repeat (4) add_window(16'd0);

    // split at a pause, speech resumed after it
    add_reg(CFG_SPLIT_PAUSE, 32'd400);
    add_window(16'd65535);
    add_window(16'd0);
    add_window(16'd0);
    add_window(16'd65535);
    add_window(16'd0);
    add_eos(32'd12345);

    // threshold below gap, window of zero, write to an unused index
    add_reg(CFG_THRESHOLD, pad16(16'd100));
    add_reg(CFG_GAP, pad16(16'd200));
    add_reg(CFG_WINDOW, pad16(16'd0));
    add_reg(CFG_UNUSED, $urandom());
    add_window(16'd0);
    add_window(16'd150);
    add_window(16'd0);
    add_eos(32'd7);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          thr_p = '0; gap_p = '0; win_p = '0;
          min_sil_p = '0; pause_p = '0; speech_p = '0; max_p = '0;
        end
        1: begin
          thr_p = '1; gap_p = '1; win_p = '1;
          min_sil_p = '1; pause_p = '1; speech_p = '1; max_p = '1;
        end
        default: begin
          thr_p = prob_t'($urandom_range(8000, 56000));
          gap_p = ($urandom_range(0, 3) == 0) ? prob_t'($urandom()) :
                                                prob_t'($urandom_range(0, 16000));
          win_p = ($urandom_range(0, 4) == 0) ? win_t'(1) : win_t'($urandom_range(16, 4096));
          min_sil_p = pick_len(win_p, 3);
          pause_p   = pick_len(win_p, 4);
          speech_p  = pick_len(win_p, 8);
          max_p     = ($urandom_range(0, 2) == 0) ? '1 :
                      count_t'(win_p) * $urandom_range(6, 40);
        end
      endcase
      low_p = (thr_p > gap_p) ? prob_t'(thr_p - gap_p) : '0;
      add_reg(CFG_THRESHOLD, pad16(thr_p));
      add_reg(CFG_GAP, pad16(gap_p));
      add_reg(CFG_WINDOW, pad16(win_p));
      add_reg(CFG_MIN_SILENCE, min_sil_p);
      add_reg(CFG_SPLIT_PAUSE, pause_p);
      add_reg(CFG_MIN_SPEECH, speech_p);
      add_reg(CFG_MAX_SPEECH, max_p);
      if (ph == 3) add_marker(ACT_HOLD);

      n = 0;
      while (n < PHASE_ITEMS) begin
        if (n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 12) add_marker(ACT_DRAIN);
        if ($urandom_range(0, 99) < 3) begin
          add_eos(pick_stream_len());
          n++;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: t = RUN_SPEECH;
            4, 5:       t = RUN_BAND;
            6, 7, 8:    t = RUN_SILENCE;
            default:    t = RUN_NOISE;
          endcase
          run_len = $urandom_range(1, (t == RUN_SILENCE) ? 12 : 8);
          for (int k = 0; k < run_len && n < PHASE_ITEMS; k++) begin
            add_window(pick_prob(t, thr_p, low_p));
            n++;
          end
        end
      end
    end
    add_eos(pick_stream_len());

    @(posedge rst_ni);
    while (windows_to_send.size() > 0 || in_valid_i || segments_due.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);
    if (bad_segments == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // ---------------- input side ----------------

  always @(negedge clk_i) begin : send_items
    stim_t  head;
    logic   nv, nwe, nkind;
    prob_t  nprob;
    count_t nlen, ndata;
    idx_t   nidx;
    int unsigned nhold;
    if (!in_valid_i && segments_due.size() == 0) settle++;
    else settle = 0;
    nv    = in_valid_i;
    nwe   = 1'b0;
    nkind = kind_i;
    nprob = speech_prob_i;
    nlen  = stream_length_i;
    nidx  = cfg_idx_i;
    ndata = cfg_data_i;
    nhold = hold_reqs;
    if (rst_ni && (item_taken || !in_valid_i)) begin
      item_taken = 1'b0;
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (windows_to_send.size() > 0) begin
        head = windows_to_send[0];
        case (head.act)
          ACT_WINDOW: begin
            nv    = 1'b1;
            nkind = head.kind;
            nprob = head.prob;
            nlen  = head.len;
            void'(windows_to_send.pop_front());
            gap_left = rand_gap();
          end
          // registers only change once the block has gone quiet
          ACT_REG: if (settle >= SETTLE_CYCLES) begin
            nwe   = 1'b1;
            nidx  = head.idx;
            ndata = head.data;
            void'(windows_to_send.pop_front());
          end
          ACT_DRAIN: if (settle >= SETTLE_CYCLES) void'(windows_to_send.pop_front());
          default: begin
            nhold = hold_reqs + 1;
            void'(windows_to_send.pop_front());
          end
        endcase
      end
    end
    in_valid_i      <= nv;
    cfg_we_i        <= nwe;
    kind_i          <= nkind;
    speech_prob_i   <= nprob;
    stream_length_i <= nlen;
    cfg_idx_i       <= nidx;
    cfg_data_i      <= ndata;
    hold_reqs       <= nhold;
  end

  // ---------------- output side ----------------

  always @(negedge clk_i) begin : stall_results
    logic ns;
    if (hold_reqs != hold_done) begin
      hold_done = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      ns = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      ns = 1'b1;
      stall_left--;
    end else begin
      stall_left = rand_gap();
      ns = (stall_left > 0);
      if (ns) stall_left--;
    end
    out_stall_i <= ns;
  end

  function automatic void flag_bad(string msg);
    bad_segments++;
    if (bad_segments <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin : observe
    segment_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (out_valid_o && !out_stall_i) begin
        if (segments_due.size() == 0) begin
          flag_bad($sformatf("unexpected segment start=%0d end=%0d reason=%0d",
                             seg_start_o, seg_end_o, end_reason_o));
        end else begin
          want = segments_due.pop_front();
          if (seg_start_o !== want.start || seg_end_o !== want.stop ||
              end_reason_o !== want.reason)
            flag_bad($sformatf("segment exp start=%0d end=%0d reason=%0d, got %0d %0d %0d",
                               want.start, want.stop, want.reason,
                               seg_start_o, seg_end_o, end_reason_o));
        end
      end
      if (cfg_we_i) load_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        track_window(kind_i, speech_prob_i, stream_length_i);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
